[sv/tsrs_pkg.sv]
package tsrs_pkg;

    localparam int ROW_W     = 13;
    localparam int COL_W     = 13;
    localparam int ELEV_W    = 24;
    localparam int CS_W      = 20;
    localparam int TAN_W     = 24;
    localparam int TAN_FRAC  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam int MAX_ROWS = 4096;
    localparam int MAX_COLS = 4096;
    localparam int LIM_W    = 17;
    localparam logic [LIM_W-1:0] ROW_LIMIT = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0] COL_LIMIT = LIM_W'(MAX_COLS);

    localparam int Q_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_SUN   = 1'b1;

    localparam logic [CS_W-1:0]  CS_RESET  = CS_W'(1000);
    localparam logic [TAN_W-1:0] TAN_RESET = TAN_W'(65536);

    // distance terms
    localparam int DIFF_W = ROW_W + 1;
    localparam int SQ_W   = 2 * ROW_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int DROP_W = ELEV_W + 1;
    localparam int D2_W   = 2 * ELEV_W;
    localparam int K_W    = 2 * (TAN_W + CS_W);

    // chunked multiplier
    localparam int A_CHUNK  = 24;
    localparam int A_CHUNKS = 4;
    localparam int A_W      = A_CHUNK * A_CHUNKS;
    localparam int B_W      = SUM_W;
    localparam int MUL_W    = A_CHUNK + B_W;
    localparam int ACC_W    = A_W + B_W;
    localparam int IDX_W    = $clog2(A_CHUNKS);

    typedef struct packed {
        logic                     ray_start;
        logic                     cell_ok;
        logic                     is_ridge;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [ELEV_W-1:0] elevation;
    } cell_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] last;
        logic [A_W-1:0]   a;
        logic [B_W-1:0]   b;
    } mac_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] prod;
    } mac_rsp_t;

endpackage

[sv/tsrs_front.sv]
module tsrs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              ray_start,
    input  logic [tsrs_pkg::ROW_W-1:0]        row,
    input  logic [tsrs_pkg::COL_W-1:0]        col,
    input  logic signed [tsrs_pkg::ELEV_W-1:0] elevation,
    input  logic                              is_ridge,
    input  logic                              is_nodata,
    output logic                              q_valid,
    output tsrs_pkg::cell_t                   q_item,
    input  logic                              q_pop
);
    import tsrs_pkg::*;

    cell_t      slot_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    logic       in_grid;
    cell_t      in_item;

    // out-of-grid cells are handled as no-data
    always_comb
    begin
        in_grid = (row != '0) && (col != '0)
               && (LIM_W'(row) <= ROW_LIMIT) && (LIM_W'(col) <= COL_LIMIT);
        in_item.ray_start = ray_start;
        in_item.cell_ok   = in_grid && !is_nodata;
        in_item.is_ridge  = is_ridge;
        in_item.row       = row;
        in_item.col       = col;
        in_item.elevation = elevation;
    end

    assign in_stall = (count_reg == 2'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[sv/tsrs_mac.sv]
module tsrs_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  tsrs_pkg::mac_req_t req,
    output tsrs_pkg::mac_rsp_t rsp
);
    import tsrs_pkg::*;

    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_reg;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [A_CHUNK-1:0] chunk;
    logic [MUL_W-1:0] prod;

    // one chunk of a times b per cycle, accumulated at its weight
    always_comb
    begin
        chunk     = a_reg[idx_reg*A_CHUNK +: A_CHUNK];
        prod      = MUL_W'(chunk) * MUL_W'(b_reg);
        idx_next  = idx_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (req.start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (ACC_W'(prod) << (A_CHUNK * int'(idx_reg)));
            if (idx_reg == last_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.start)
        begin
            a_reg    <= req.a;
            b_reg    <= req.b;
            last_reg <= req.last;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

[sv/tsrs_back.sv]
module tsrs_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsrs_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             q_valid,
    input  tsrs_pkg::cell_t                  q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             write_shadow,
    output logic                             shadow
);
    import tsrs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_EVAL = 8'b0000_0010,
        ST_SUM  = 8'b0000_0100,
        ST_K0   = 8'b0000_1000,
        ST_K1   = 8'b0001_0000,
        ST_K2   = 8'b0010_0000,
        ST_SMUL = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CS_W-1:0]  cell_size_reg, cell_size_next;
    logic [TAN_W-1:0] tan_reg, tan_next;

    cell_t item_reg, item_next;

    logic [ROW_W-1:0]         ridge_row_reg, ridge_row_next;
    logic [COL_W-1:0]         ridge_col_reg, ridge_col_next;
    logic signed [ELEV_W-1:0] ridge_elev_reg, ridge_elev_next;
    logic                     have_ridge_reg, have_ridge_next;
    logic                     shading_reg, shading_next;

    logic [D2_W-1:0]  d2_reg, d2_next;
    logic [SQ_W-1:0]  dr2_reg, dr2_next;
    logic [SQ_W-1:0]  dc2_reg, dc2_next;
    logic [SUM_W-1:0] s_reg, s_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             k_valid_reg, k_valid_next;

    logic res_wr_reg, res_wr_next;
    logic res_sh_reg, res_sh_next;
    logic out_valid_reg, out_valid_next;
    logic out_write_reg, out_write_next;
    logic out_shadow_reg, out_shadow_next;

    logic signed [DROP_W-1:0] drop;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] dc;
    logic [DIFF_W-1:0]        adr;
    logic [DIFF_W-1:0]        adc;
    logic [ELEV_W-1:0]        drop_mag;
    logic                     drop_pos;
    logic [SUM_W-1:0]         s_sum;
    logic                     lit;
    logic                     out_free;

    mac_req_t mac_req;
    mac_rsp_t mac_rsp;

    tsrs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    always_comb
    begin
        drop     = $signed({ridge_elev_reg[ELEV_W-1], ridge_elev_reg})
                 - $signed({item_reg.elevation[ELEV_W-1], item_reg.elevation});
        dr       = $signed({1'b0, ridge_row_reg}) - $signed({1'b0, item_reg.row});
        dc       = $signed({1'b0, ridge_col_reg}) - $signed({1'b0, item_reg.col});
        adr      = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
        adc      = dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
        drop_mag = drop[ELEV_W-1:0];
        drop_pos = !drop[DROP_W-1] && (drop != '0);
        s_sum    = SUM_W'(dr2_reg) + SUM_W'(dc2_reg);
        // squared test, both sides scaled by the q8.16 fraction squared
        lit      = (ACC_W'(d2_reg) << (2 * TAN_FRAC)) <= mac_rsp.prod;
        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next      = state_reg;
        cell_size_next  = cell_size_reg;
        tan_next        = tan_reg;
        item_next       = item_reg;
        ridge_row_next  = ridge_row_reg;
        ridge_col_next  = ridge_col_reg;
        ridge_elev_next = ridge_elev_reg;
        have_ridge_next = have_ridge_reg;
        shading_next    = shading_reg;
        d2_next         = d2_reg;
        dr2_next        = dr2_reg;
        dc2_next        = dc2_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        k_valid_next    = k_valid_reg;
        res_wr_next     = res_wr_reg;
        res_sh_next     = res_sh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_write_next  = out_write_reg;
        out_shadow_next = out_shadow_reg;
        q_pop           = 1'b0;
        mac_req.start   = 1'b0;
        mac_req.last    = '0;
        mac_req.a       = A_W'(tan_reg);
        mac_req.b       = B_W'(cell_size_reg);

        if (cfg_we)
        begin
            k_valid_next = 1'b0;
            case (cfg_index)
                CFG_CELL_SIZE: cell_size_next = cfg_data[CS_W-1:0];
                CFG_TAN_SUN:   tan_next       = cfg_data[TAN_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.ray_start)
                    begin
                        ridge_row_next  = '0;
                        ridge_col_next  = '0;
                        ridge_elev_next = '0;
                        have_ridge_next = 1'b0;
                        shading_next    = 1'b0;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                res_wr_next = 1'b0;
                res_sh_next = 1'b0;
                state_next  = ST_EMIT;
                if (item_reg.cell_ok)
                begin
                    if (item_reg.is_ridge && !have_ridge_reg)
                    begin
                        ridge_row_next  = item_reg.row;
                        ridge_col_next  = item_reg.col;
                        ridge_elev_next = item_reg.elevation;
                        have_ridge_next = 1'b1;
                        shading_next    = 1'b1;
                    end
                    else if (item_reg.is_ridge || shading_reg)
                    begin
                        res_wr_next = 1'b1;
                        if (!drop_pos)
                        begin
                            // cell not below the ridge: lit at once
                            if (item_reg.is_ridge)
                            begin
                                ridge_row_next  = item_reg.row;
                                ridge_col_next  = item_reg.col;
                                ridge_elev_next = item_reg.elevation;
                            end
                            else
                            begin
                                shading_next = 1'b0;
                            end
                        end
                        else
                        begin
                            d2_next    = D2_W'(drop_mag) * D2_W'(drop_mag);
                            dr2_next   = SQ_W'(adr[DIFF_W-2:0]) * SQ_W'(adr[DIFF_W-2:0]);
                            dc2_next   = SQ_W'(adc[DIFF_W-2:0]) * SQ_W'(adc[DIFF_W-2:0]);
                            state_next = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM:
            begin
                s_next        = s_sum;
                mac_req.start = 1'b1;
                if (k_valid_reg)
                begin
                    // tan^2 * cell_size^2 times squared distance
                    mac_req.last = IDX_W'(3);
                    mac_req.a    = A_W'(k_reg);
                    mac_req.b    = s_sum;
                    state_next   = ST_SMUL;
                end
                else
                begin
                    // tan * cell_size
                    mac_req.last = IDX_W'(0);
                    mac_req.a    = A_W'(tan_reg);
                    mac_req.b    = B_W'(cell_size_reg);
                    state_next   = ST_K0;
                end
            end
            ST_K0:
            begin
                if (mac_rsp.done)
                begin
                    mac_req.start = 1'b1;
                    mac_req.last  = IDX_W'(1);
                    mac_req.a     = A_W'(mac_rsp.prod);
                    mac_req.b     = B_W'(tan_reg);
                    state_next    = ST_K1;
                end
            end
            ST_K1:
            begin
                if (mac_rsp.done)
                begin
                    mac_req.start = 1'b1;
                    mac_req.last  = IDX_W'(2);
                    mac_req.a     = A_W'(mac_rsp.prod);
                    mac_req.b     = B_W'(cell_size_reg);
                    state_next    = ST_K2;
                end
            end
            ST_K2:
            begin
                if (mac_rsp.done)
                begin
                    k_next        = mac_rsp.prod[K_W-1:0];
                    k_valid_next  = 1'b1;
                    mac_req.start = 1'b1;
                    mac_req.last  = IDX_W'(3);
                    mac_req.a     = A_W'(mac_rsp.prod);
                    mac_req.b     = s_reg;
                    state_next    = ST_SMUL;
                end
            end
            ST_SMUL:
            begin
                if (mac_rsp.done)
                begin
                    if (lit)
                    begin
                        res_sh_next = 1'b0;
                        if (item_reg.is_ridge)
                        begin
                            ridge_row_next  = item_reg.row;
                            ridge_col_next  = item_reg.col;
                            ridge_elev_next = item_reg.elevation;
                        end
                        else
                        begin
                            shading_next = 1'b0;
                        end
                    end
                    else
                    begin
                        res_sh_next = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_write_next  = res_wr_reg;
                    out_shadow_next = res_sh_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_size_reg  <= CS_RESET;
            tan_reg        <= TAN_RESET;
            ridge_row_reg  <= '0;
            ridge_col_reg  <= '0;
            ridge_elev_reg <= '0;
            have_ridge_reg <= 1'b0;
            shading_reg    <= 1'b0;
            k_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cell_size_reg  <= cell_size_next;
            tan_reg        <= tan_next;
            ridge_row_reg  <= ridge_row_next;
            ridge_col_reg  <= ridge_col_next;
            ridge_elev_reg <= ridge_elev_next;
            have_ridge_reg <= have_ridge_next;
            shading_reg    <= shading_next;
            k_valid_reg    <= k_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        d2_reg         <= d2_next;
        dr2_reg        <= dr2_next;
        dc2_reg        <= dc2_next;
        s_reg          <= s_next;
        k_reg          <= k_next;
        res_wr_reg     <= res_wr_next;
        res_sh_reg     <= res_sh_next;
        out_write_reg  <= out_write_next;
        out_shadow_reg <= out_shadow_next;
    end

    assign out_valid    = out_valid_reg;
    assign write_shadow = out_write_reg;
    assign shadow       = out_shadow_reg;

endmodule

[sv/terrain_shadow_ray_scan_core.sv]
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   ray_start row col elevation is_ridge is_nodata
// out       output     out_valid/out_stall write_shadow shadow
// cfg       input      cfg_we              cfg_index cfg_data
//
// a cell that needs no distance test goes from the queue through ST_EVAL and ST_EMIT to the result register
// a tested cell multiplies as four 24-bit chunks through the shared multiplier
// the first tested cell after a config write first rebuilds tan^2 * cell_size^2 in ST_K0, ST_K1 and ST_K2
// reset clears the ridge state and loads cell_size 1000, tan_sun_elevation 1.0
// a two-beat queue and the result register let either side stall on its own
module terrain_shadow_ray_scan_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tsrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsrs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               ray_start,
    input  logic [tsrs_pkg::ROW_W-1:0]         row,
    input  logic [tsrs_pkg::COL_W-1:0]         col,
    input  logic signed [tsrs_pkg::ELEV_W-1:0] elevation,
    input  logic                               is_ridge,
    input  logic                               is_nodata,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               write_shadow,
    output logic                               shadow
);
    import tsrs_pkg::*;

    logic  q_valid;
    logic  q_pop;
    cell_t q_item;

    tsrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ray_start (ray_start),
        .row       (row),
        .col       (col),
        .elevation (elevation),
        .is_ridge  (is_ridge),
        .is_nodata (is_nodata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    tsrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_shadow (write_shadow),
        .shadow       (shadow)
    );

endmodule
